/* hdl/escsf_pkg.sv */
`timescale 1ns / 1ps

package escsf_pkg;

    // Field and port widths.
    localparam int unsigned PW_W       = 12;
    localparam int unsigned CNT_W      = 16;
    localparam int unsigned PCT_W      = 16;
    localparam int unsigned CODE_W     = 8;
    localparam int unsigned OP_W       = 2;
    localparam int unsigned MODE_W     = 3;
    localparam int unsigned STAGE_W    = 2;
    localparam int unsigned REQ_W      = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned S_DATA_W   = 48;
    localparam int unsigned S_USER_W   = 2;
    localparam int unsigned RES_DATA_W = MODE_W + STAGE_W + 2 * PW_W;
    localparam int unsigned M_DATA_W   = 32;

    // Pulse width limits and calibration stage lengths.
    localparam int STEER_MIN_WIDTH = 1000;
    localparam int STEER_MAX_WIDTH = 2000;
    localparam int MOTOR_MIN_WIDTH = 1000;
    localparam int MOTOR_MAX_WIDTH = 2000;
    localparam logic [CNT_W-1:0] FORWARD_TICKS = 16'd100;
    localparam logic [CNT_W-1:0] REVERSE_TICKS = 16'd100;

    // Item kinds.
    localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
    localparam logic [OP_W-1:0] OP_SETPOINT = 2'd1;
    localparam logic [OP_W-1:0] OP_REQUEST  = 2'd2;
    localparam logic [OP_W-1:0] OP_VISION   = 2'd3;

    // Mode machine states.
    localparam logic [MODE_W-1:0] MODE_DISABLED  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PREENABLE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ENABLED   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PRECAL    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CALIB     = 3'd4;

    // Calibration stages.
    localparam logic [STAGE_W-1:0] STAGE_INACTIVE = 2'd0;
    localparam logic [STAGE_W-1:0] STAGE_FORWARD  = 2'd1;
    localparam logic [STAGE_W-1:0] STAGE_REVERSE  = 2'd2;
    localparam logic [STAGE_W-1:0] STAGE_COMPLETE = 2'd3;

    // Latched request codes (incoming request code plus one).
    localparam logic [REQ_W-1:0] REQ_EMPTY   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DISABLE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ENABLE  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_PREPARE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PERFORM = 3'd4;
    localparam logic [CODE_W-1:0] REQ_CODE_MAX = 8'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STEER_NEUTRAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_NEUTRAL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEER_STEP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NEED_NEUTRAL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_DIS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_VISION_DIS     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS  = 3'd7;

    // Configuration reset values.
    localparam logic [PW_W-1:0]  NEUTRAL_RESET = 12'd1500;
    localparam logic [PW_W-1:0]  STEP_RESET    = 12'd10;
    localparam logic [CNT_W-1:0] TIMEOUT_RESET = 16'd20;

    // Percent scaling: offset percent in 0..PCT_SPAN, times the width span,
    // divided by PCT_SPAN through an exact reciprocal multiply.
    localparam int PCT_LIMIT = 10000;
    localparam int PCT_SPAN  = 2 * PCT_LIMIT;
    localparam int unsigned POS_W     = 15;
    localparam int unsigned PROD_W    = 26;
    localparam int unsigned DIV_SHIFT = 41;
    localparam int unsigned DIV_MUL_W = 27;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL =
        DIV_MUL_W'(((64'd1 << DIV_SHIFT) + 64'(PCT_SPAN) - 64'd1) / 64'(PCT_SPAN));

    localparam int STEER_SPAN     = STEER_MAX_WIDTH - STEER_MIN_WIDTH;
    localparam bit STEER_DESC     = (STEER_SPAN < 0);
    localparam int STEER_SPAN_ABS = STEER_DESC ? -STEER_SPAN : STEER_SPAN;
    localparam int MOTOR_SPAN     = MOTOR_MAX_WIDTH - MOTOR_MIN_WIDTH;
    localparam bit MOTOR_DESC     = (MOTOR_SPAN < 0);
    localparam int MOTOR_SPAN_ABS = MOTOR_DESC ? -MOTOR_SPAN : MOTOR_SPAN;

    typedef struct packed {
        logic [PW_W-1:0]  steer_neutral_width;
        logic [PW_W-1:0]  motor_neutral_width;
        logic [PW_W-1:0]  steer_slew_step;
        logic [PW_W-1:0]  motor_slew_step;
        logic             need_neutral_to_enable;
        logic             timeout_may_disable;
        logic             vision_may_disable;
        logic [CNT_W-1:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [PROD_W-1:0] steer_prod;
        logic [PROD_W-1:0] motor_prod;
        logic [CODE_W-1:0] request_code;
        logic [CODE_W-1:0] vision_code;
    } item_t;

    typedef struct packed {
        logic               from_tick;
        logic [MODE_W-1:0]  mode;
        logic [STAGE_W-1:0] calib_stage;
        logic [PW_W-1:0]    steer_width;
        logic [PW_W-1:0]    motor_width;
    } result_t;

    // Clamp a percent to the legal range and shift it to start at zero.
    function automatic logic [POS_W-1:0] pct_offset(input logic signed [PCT_W-1:0] pct);
        logic [POS_W-1:0] off;
        if (int'(pct) < -PCT_LIMIT) begin
            off = '0;
        end else if (int'(pct) > PCT_LIMIT) begin
            off = POS_W'(PCT_SPAN);
        end else begin
            off = POS_W'(int'(pct) + PCT_LIMIT);
        end
        return off;
    endfunction

    // Exact floor(prod / PCT_SPAN) for every product the scaling can give.
    function automatic logic [PW_W-1:0] div_span(input logic [PROD_W-1:0] prod);
        logic [PROD_W+DIV_MUL_W-1:0] full;
        full = (PROD_W + DIV_MUL_W)'(prod) * (PROD_W + DIV_MUL_W)'(DIV_MUL);
        return full[DIV_SHIFT +: PW_W];
    endfunction

    // Add or subtract the scaled quotient, following the sign of the span.
    function automatic logic [PW_W-1:0] apply_span(input int lo, input bit desc,
                                                  input logic [PW_W-1:0] q);
        logic [PW_W-1:0] w;
        w = desc ? (PW_W'(lo) - q) : (PW_W'(lo) + q);
        return w;
    endfunction

    // Move a command toward its target by at most one step.
    function automatic logic [PW_W-1:0] slew(input logic [PW_W-1:0] cmd,
                                             input logic [PW_W-1:0] tgt,
                                             input logic [PW_W-1:0] step);
        logic            up;
        logic [PW_W-1:0] diff;
        logic [PW_W-1:0] res;
        up   = (tgt > cmd);
        diff = up ? (tgt - cmd) : (cmd - tgt);
        if (diff > step) begin
            res = up ? (cmd + step) : (cmd - step);
        end else begin
            res = tgt;
        end
        return res;
    endfunction

    // Saturating counter increment.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : (v + CNT_W'(1));
    endfunction

endpackage

/* hdl/escsf_cfg.sv */
`timescale 1ns / 1ps

module escsf_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [escsf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [escsf_pkg::CFG_DATA_W-1:0] cfg_data,
    output escsf_pkg::cfg_t                  cfg
);
    import escsf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register write decode.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_STEER_NEUTRAL: cfg_next.steer_neutral_width    = cfg_data[PW_W-1:0];
                CFG_MOTOR_NEUTRAL: cfg_next.motor_neutral_width    = cfg_data[PW_W-1:0];
                CFG_STEER_STEP:    cfg_next.steer_slew_step        = cfg_data[PW_W-1:0];
                CFG_MOTOR_STEP:    cfg_next.motor_slew_step        = cfg_data[PW_W-1:0];
                CFG_NEED_NEUTRAL:  cfg_next.need_neutral_to_enable = cfg_data[0];
                CFG_TIMEOUT_DIS:   cfg_next.timeout_may_disable    = cfg_data[0];
                CFG_VISION_DIS:    cfg_next.vision_may_disable     = cfg_data[0];
                CFG_TIMEOUT_TICKS: cfg_next.timeout_ticks          = cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.steer_neutral_width    <= NEUTRAL_RESET;
            cfg_reg.motor_neutral_width    <= NEUTRAL_RESET;
            cfg_reg.steer_slew_step        <= STEP_RESET;
            cfg_reg.motor_slew_step        <= STEP_RESET;
            cfg_reg.need_neutral_to_enable <= 1'b1;
            cfg_reg.timeout_may_disable    <= 1'b1;
            cfg_reg.vision_may_disable     <= 1'b1;
            cfg_reg.timeout_ticks          <= TIMEOUT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* hdl/escsf_front.sv */
`timescale 1ns / 1ps

module escsf_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [escsf_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [escsf_pkg::S_USER_W-1:0] s_tuser,
    input  logic                           advance,
    output escsf_pkg::item_t               item,
    output logic                           item_valid
);
    import escsf_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    logic  load;

    // The register frees up whenever its item moves on to the core.
    assign s_tready   = !valid_reg || advance;
    assign load       = s_tvalid && s_tready;
    assign item       = item_reg;
    assign item_valid = valid_reg;

    // Clamp and scale both percents on the way in; the division follows later.
    always_comb begin
        item_next.operation    = s_tuser[OP_W-1:0];
        item_next.steer_prod   = PROD_W'(pct_offset(s_tdata[15:0])) * PROD_W'(STEER_SPAN_ABS);
        item_next.motor_prod   = PROD_W'(pct_offset(s_tdata[31:16])) * PROD_W'(MOTOR_SPAN_ABS);
        item_next.request_code = s_tdata[39:32];
        item_next.vision_code  = s_tdata[47:40];
    end

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item_next;
        end
    end

endmodule

/* hdl/escsf_core.sv */
`timescale 1ns / 1ps

module escsf_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  escsf_pkg::item_t    item,
    input  escsf_pkg::cfg_t     cfg,
    output escsf_pkg::result_t  result
);
    import escsf_pkg::*;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [STAGE_W-1:0] stage;
        logic [REQ_W-1:0]   pend;
        logic               verr;
        logic [CNT_W-1:0]   motor_idle;
        logic [CNT_W-1:0]   steer_idle;
        logic [CNT_W-1:0]   calib_ticks;
        logic [PW_W-1:0]    steer_target;
        logic [PW_W-1:0]    steer_cmd;
        logic [PW_W-1:0]    motor_target;
        logic [PW_W-1:0]    motor_cmd;
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    logic            disable_req;
    logic            timed_out;
    logic [PW_W-1:0] steer_map;
    logic [PW_W-1:0] motor_map;

    // Set point widths from the scaled products.
    assign steer_map = apply_span(STEER_MIN_WIDTH, STEER_DESC, div_span(item.steer_prod));
    assign motor_map = apply_span(MOTOR_MIN_WIDTH, MOTOR_DESC, div_span(item.motor_prod));

    assign disable_req = (state_reg.pend == REQ_DISABLE);
    assign timed_out   = (state_reg.motor_idle > cfg.timeout_ticks) ||
                         (state_reg.steer_idle > cfg.timeout_ticks);

    // One item's whole update of the state.
    always_comb begin
        state_next = state_reg;
        case (item.operation)
            OP_TICK: begin
                // Mode transitions.
                case (state_reg.mode)
                    MODE_DISABLED: begin
                        if (state_reg.pend == REQ_ENABLE) begin
                            state_next.mode = MODE_PREENABLE;
                        end else if (state_reg.pend == REQ_PREPARE) begin
                            state_next.mode = MODE_PRECAL;
                        end
                    end
                    MODE_PREENABLE: begin
                        if (disable_req) begin
                            state_next.mode = MODE_DISABLED;
                        end else if (!cfg.need_neutral_to_enable ||
                                     state_reg.motor_cmd == cfg.motor_neutral_width) begin
                            state_next.mode = MODE_ENABLED;
                        end
                    end
                    MODE_ENABLED: begin
                        if (disable_req || (cfg.timeout_may_disable && timed_out) ||
                            (cfg.vision_may_disable && state_reg.verr)) begin
                            state_next.mode = MODE_DISABLED;
                        end
                    end
                    MODE_PRECAL: begin
                        if (disable_req) begin
                            state_next.mode = MODE_DISABLED;
                        end else if (state_reg.pend == REQ_PERFORM) begin
                            state_next.mode  = MODE_CALIB;
                            state_next.stage = STAGE_FORWARD;
                        end
                    end
                    default: begin
                        if (disable_req) begin
                            state_next.mode = MODE_DISABLED;
                        end
                        if (state_reg.stage == STAGE_COMPLETE) begin
                            state_next.mode  = MODE_DISABLED;
                            state_next.stage = STAGE_INACTIVE;
                        end
                    end
                endcase

                // Calibration stage advance.
                if (state_next.stage == STAGE_FORWARD &&
                    state_reg.calib_ticks > FORWARD_TICKS) begin
                    state_next.stage       = STAGE_REVERSE;
                    state_next.calib_ticks = '0;
                end else if (state_next.stage == STAGE_REVERSE &&
                             state_reg.calib_ticks > REVERSE_TICKS) begin
                    state_next.stage       = STAGE_COMPLETE;
                    state_next.calib_ticks = '0;
                end

                // Action of the new mode.
                case (state_next.mode)
                    MODE_ENABLED: begin
                        state_next.steer_cmd = slew(state_reg.steer_cmd, state_reg.steer_target,
                                                    cfg.steer_slew_step);
                        state_next.motor_cmd = slew(state_reg.motor_cmd, state_reg.motor_target,
                                                    cfg.motor_slew_step);
                        if (state_next.motor_cmd != cfg.motor_neutral_width) begin
                            state_next.motor_idle = sat_inc(state_reg.motor_idle);
                            state_next.steer_idle = sat_inc(state_reg.steer_idle);
                        end
                        state_next.calib_ticks = '0;
                    end
                    MODE_CALIB: begin
                        state_next.steer_target = cfg.steer_neutral_width;
                        state_next.steer_cmd    = slew(state_reg.steer_cmd,
                                                       cfg.steer_neutral_width,
                                                       cfg.steer_slew_step);
                        if (state_next.stage != STAGE_INACTIVE) begin
                            if (state_next.stage == STAGE_FORWARD) begin
                                state_next.motor_target = PW_W'(MOTOR_MAX_WIDTH);
                            end else if (state_next.stage == STAGE_REVERSE) begin
                                state_next.motor_target = PW_W'(MOTOR_MIN_WIDTH);
                            end else begin
                                state_next.motor_target = cfg.motor_neutral_width;
                            end
                            state_next.motor_cmd = slew(state_reg.motor_cmd,
                                                        state_next.motor_target,
                                                        cfg.motor_slew_step);
                        end
                        state_next.motor_idle  = '0;
                        state_next.steer_idle  = '0;
                        state_next.calib_ticks = sat_inc(state_next.calib_ticks);
                    end
                    default: begin
                        state_next.motor_target = cfg.motor_neutral_width;
                        state_next.motor_cmd    = slew(state_reg.motor_cmd,
                                                       cfg.motor_neutral_width,
                                                       cfg.motor_slew_step);
                        state_next.steer_target = cfg.steer_neutral_width;
                        state_next.steer_cmd    = slew(state_reg.steer_cmd,
                                                       cfg.steer_neutral_width,
                                                       cfg.steer_slew_step);
                        state_next.motor_idle   = '0;
                        state_next.steer_idle   = '0;
                        state_next.calib_ticks  = '0;
                    end
                endcase

                state_next.pend = REQ_EMPTY;
                state_next.verr = 1'b0;
            end
            OP_SETPOINT: begin
                state_next.steer_target = steer_map;
                state_next.motor_target = motor_map;
                state_next.steer_idle   = '0;
                state_next.motor_idle   = '0;
            end
            OP_REQUEST: begin
                // Unknown codes leave the pending request alone.
                if (item.request_code <= REQ_CODE_MAX) begin
                    state_next.pend = REQ_W'(item.request_code) + REQ_W'(1);
                end
            end
            default: begin
                if (item.vision_code != '0) begin
                    state_next.verr = 1'b1;
                end
            end
        endcase
    end

    // The result reports the state after the item.
    always_comb begin
        result.from_tick   = (item.operation == OP_TICK);
        result.mode        = state_next.mode;
        result.calib_stage = state_next.stage;
        result.steer_width = state_next.steer_cmd;
        result.motor_width = state_next.motor_cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode         <= MODE_DISABLED;
            state_reg.stage        <= STAGE_INACTIVE;
            state_reg.pend         <= REQ_EMPTY;
            state_reg.verr         <= 1'b0;
            state_reg.motor_idle   <= '0;
            state_reg.steer_idle   <= '0;
            state_reg.calib_ticks  <= '0;
            state_reg.steer_target <= NEUTRAL_RESET;
            state_reg.steer_cmd    <= NEUTRAL_RESET;
            state_reg.motor_target <= NEUTRAL_RESET;
            state_reg.motor_cmd    <= NEUTRAL_RESET;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    // Only ticks move the mode machine.
    a_mode_only_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.operation != OP_TICK |=> state_reg.mode == $past(state_reg.mode))
        else $error("mode changed on a non-tick item");

    // A tick consumes the latched request and vision error.
    a_tick_clears_latches: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.operation == OP_TICK |=> state_reg.pend == REQ_EMPTY && !state_reg.verr)
        else $error("latched request or vision error survived a tick");

    // The calibration counter runs only while calibrating.
    a_calib_count_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.mode != MODE_CALIB |-> state_reg.calib_ticks == '0)
        else $error("calibration count nonzero outside calibrate mode");

    // Idle counters run only while enabled.
    a_idle_count_enabled: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.mode != MODE_ENABLED |->
            state_reg.motor_idle == '0 && state_reg.steer_idle == '0)
        else $error("idle counters nonzero outside enabled mode");
`endif

endmodule

/* hdl/esc_steering_safety_fsm.sv */
`timescale 1ns / 1ps

// Channel   Ports                          Contents
// s_        tvalid tready tdata[47:0]      item: tuser operation, tdata percents and codes
//           tuser[1:0]
// m_        tvalid tready tdata[31:0]      result: tuser from_tick, tdata mode, stage, widths
//           tuser[0:0]
// cfg_      valid ready index[2:0]         register write, always ready
//           data[15:0]
//
// Every item passes through the update logic; one item is accepted per cycle while
// m_tready stays high. From input transfer to result, an item passes through
// the input register, then the state update that loads the result register.
// aresetn is synchronous: mode disabled, commands and targets at neutral 1500.
// A stalled result holds the result register; the input register still takes
// one more item, after which s_tready follows m_tready.
module esc_steering_safety_fsm (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input items.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [15:0] steer_percent, [31:16] motor_percent, [39:32] request_code,
    // [47:40] vision_code
    input  logic [escsf_pkg::S_DATA_W-1:0]   s_tdata,
    // [1:0] operation
    input  logic [escsf_pkg::S_USER_W-1:0]   s_tuser,
    // Results.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [2:0] mode, [4:3] calib_stage, [16:5] steer_width, [28:17] motor_width,
    // [31:29] zero
    output logic [escsf_pkg::M_DATA_W-1:0]   m_tdata,
    // [0] from_tick
    output logic [0:0]                       m_tuser,
    // Configuration writes.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [escsf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [escsf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import escsf_pkg::*;

    cfg_t    cfg;
    item_t   item;
    logic    item_valid;
    logic    advance;
    logic    fire;
    result_t result;
    result_t result_reg;
    logic    out_valid_reg;
    logic    out_valid_next;

    // The core moves when the result register is free or being emptied.
    assign advance = !out_valid_reg || m_tready;
    assign fire    = item_valid && advance;

    escsf_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    escsf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item       (item),
        .item_valid (item_valid)
    );

    escsf_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .cfg     (cfg),
        .result  (result)
    );

    // Result register.
    always_comb begin
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= result;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tuser[0] = result_reg.from_tick;
    assign m_tdata    = {{(M_DATA_W - RES_DATA_W){1'b0}},
                         result_reg.motor_width, result_reg.steer_width,
                         result_reg.calib_stage, result_reg.mode};

`ifndef ASSERT_OFF
    // Every item the core takes shows up as a pending result next cycle.
    a_fire_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> out_valid_reg)
        else $error("processed item did not reach the result register");
`endif

endmodule

/* test/esc_steering_safety_fsm_tb.sv */
`timescale 1ns / 1ps

module esc_steering_safety_fsm_tb;
    import escsf_pkg::*;

    // Incoming request codes as they travel on the bus.
    localparam logic [CODE_W-1:0] CODE_DISABLE = 8'd0;
    localparam logic [CODE_W-1:0] CODE_ENABLE  = 8'd1;
    localparam logic [CODE_W-1:0] CODE_PREPARE = 8'd2;
    localparam logic [CODE_W-1:0] CODE_PERFORM = 8'd3;

    // Cycles without a transfer on any channel before giving up.
    localparam int STALL_LIMIT = 2000;

    // Ticks after the perform tick that carry a full calibration through the
    // complete stage and back to disabled, with some margin.
    localparam int FULL_CAL_TICKS = 212;

    typedef struct packed {
        logic [OP_W-1:0]          kind;
        logic signed [PCT_W-1:0]  steer_pct;
        logic signed [PCT_W-1:0]  motor_pct;
        logic [CODE_W-1:0]        req_code;
        logic [CODE_W-1:0]        vis_code;
    } cmd_item_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic [S_USER_W-1:0]   s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    cmd_item_t   pending_cmds [$];
    result_t     expected_status [$];
    int          errors = 0;
    int          queued = 0;
    int          idle_run = 0;
    int          send_gap = 0;
    int          sink_hold = 0;
    bit          no_idle = 1'b0;
    bit          in_taken = 1'b0;

    // Shadow of the block's registers and state.
    logic [PW_W-1:0]    steer_neutral, motor_neutral, steer_step, motor_step;
    logic               need_neutral, timeout_dis, vision_dis;
    logic [CNT_W-1:0]   timeout_lim;
    logic [MODE_W-1:0]  veh_mode;
    logic [STAGE_W-1:0] cal_stage;
    logic [REQ_W-1:0]   req_latched;
    logic               vis_err;
    logic [CNT_W-1:0]   motor_idle, steer_idle, cal_count;
    logic [PW_W-1:0]    steer_tgt, steer_cmd, motor_tgt, motor_cmd;

    esc_steering_safety_fsm u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // State of the shadow model right after reset.
    function automatic void shadow_reset();
        steer_neutral = NEUTRAL_RESET;
        motor_neutral = NEUTRAL_RESET;
        steer_step    = STEP_RESET;
        motor_step    = STEP_RESET;
        need_neutral  = 1'b1;
        timeout_dis   = 1'b1;
        vision_dis    = 1'b1;
        timeout_lim   = TIMEOUT_RESET;
        veh_mode      = MODE_DISABLED;
        cal_stage     = STAGE_INACTIVE;
        req_latched   = REQ_EMPTY;
        vis_err       = 1'b0;
        motor_idle    = '0;
        steer_idle    = '0;
        cal_count     = '0;
        steer_tgt     = NEUTRAL_RESET;
        steer_cmd     = NEUTRAL_RESET;
        motor_tgt     = NEUTRAL_RESET;
        motor_cmd     = NEUTRAL_RESET;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_STEER_NEUTRAL: steer_neutral = val[PW_W-1:0];
            CFG_MOTOR_NEUTRAL: motor_neutral = val[PW_W-1:0];
            CFG_STEER_STEP:    steer_step    = val[PW_W-1:0];
            CFG_MOTOR_STEP:    motor_step    = val[PW_W-1:0];
            CFG_NEED_NEUTRAL:  need_neutral  = val[0];
            CFG_TIMEOUT_DIS:   timeout_dis   = val[0];
            CFG_VISION_DIS:    vision_dis    = val[0];
            default:           timeout_lim   = val;
        endcase
    endfunction

    // Percent in hundredths, clamped to full scale, mapped linearly onto the
    // pulse width range with truncation.
    function automatic logic [PW_W-1:0] pct_to_us(input logic signed [PCT_W-1:0] pct,
                                                  input int lo, input int hi);
        int p;
        int w;
        p = pct;
        if (p < -PCT_LIMIT)
            p = -PCT_LIMIT;
        if (p > PCT_LIMIT)
            p = PCT_LIMIT;
        w = lo + ((hi - lo) * (p + PCT_LIMIT)) / PCT_SPAN;
        return w[PW_W-1:0];
    endfunction

    function automatic logic [PW_W-1:0] step_toward(input logic [PW_W-1:0] cur,
                                                    input logic [PW_W-1:0] goal,
                                                    input logic [PW_W-1:0] lim);
        logic [PW_W-1:0] gap;
        gap = (goal > cur) ? goal - cur : cur - goal;
        if (gap <= lim)
            return goal;
        return (goal > cur) ? cur + lim : cur - lim;
    endfunction

    function automatic logic [CNT_W-1:0] bump_sat(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // One control tick: mode machine, calibration stage machine, then the
    // mode's action on targets, commands and counters.
    function automatic void run_tick();
        logic drop_req;
        drop_req = (req_latched == REQ_DISABLE);
        case (veh_mode)
            MODE_DISABLED: begin
                if (req_latched == REQ_ENABLE)
                    veh_mode = MODE_PREENABLE;
                else if (req_latched == REQ_PREPARE)
                    veh_mode = MODE_PRECAL;
            end
            MODE_PREENABLE: begin
                if (drop_req)
                    veh_mode = MODE_DISABLED;
                else if (!need_neutral || motor_cmd == motor_neutral)
                    veh_mode = MODE_ENABLED;
            end
            MODE_ENABLED: begin
                if (drop_req)
                    veh_mode = MODE_DISABLED;
                if (timeout_dis && (motor_idle > timeout_lim || steer_idle > timeout_lim))
                    veh_mode = MODE_DISABLED;
                if (vision_dis && vis_err)
                    veh_mode = MODE_DISABLED;
            end
            MODE_PRECAL: begin
                if (drop_req) begin
                    veh_mode = MODE_DISABLED;
                end else if (req_latched == REQ_PERFORM) begin
                    veh_mode  = MODE_CALIB;
                    cal_stage = STAGE_FORWARD;
                end
            end
            default: begin
                if (drop_req)
                    veh_mode = MODE_DISABLED;
                if (cal_stage == STAGE_COMPLETE) begin
                    veh_mode  = MODE_DISABLED;
                    cal_stage = STAGE_INACTIVE;
                end
            end
        endcase

        if (cal_stage == STAGE_FORWARD && cal_count > FORWARD_TICKS) begin
            cal_stage = STAGE_REVERSE;
            cal_count = '0;
        end else if (cal_stage == STAGE_REVERSE && cal_count > REVERSE_TICKS) begin
            cal_stage = STAGE_COMPLETE;
            cal_count = '0;
        end

        if (veh_mode == MODE_ENABLED) begin
            steer_cmd = step_toward(steer_cmd, steer_tgt, steer_step);
            motor_cmd = step_toward(motor_cmd, motor_tgt, motor_step);
            if (motor_cmd != motor_neutral) begin
                motor_idle = bump_sat(motor_idle);
                steer_idle = bump_sat(steer_idle);
            end
            cal_count = '0;
        end else if (veh_mode == MODE_CALIB) begin
            steer_tgt = steer_neutral;
            steer_cmd = step_toward(steer_cmd, steer_tgt, steer_step);
            // Forward drives full throttle, reverse full brake, then back to neutral.
            if (cal_stage != STAGE_INACTIVE) begin
                if (cal_stage == STAGE_FORWARD)
                    motor_tgt = PW_W'(MOTOR_MAX_WIDTH);
                else if (cal_stage == STAGE_REVERSE)
                    motor_tgt = PW_W'(MOTOR_MIN_WIDTH);
                else
                    motor_tgt = motor_neutral;
                motor_cmd = step_toward(motor_cmd, motor_tgt, motor_step);
            end
            motor_idle = '0;
            steer_idle = '0;
            cal_count  = bump_sat(cal_count);
        end else begin
            motor_tgt  = motor_neutral;
            motor_cmd  = step_toward(motor_cmd, motor_tgt, motor_step);
            steer_tgt  = steer_neutral;
            steer_cmd  = step_toward(steer_cmd, steer_tgt, steer_step);
            motor_idle = '0;
            steer_idle = '0;
            cal_count  = '0;
        end

        req_latched = REQ_EMPTY;
        vis_err     = 1'b0;
    endfunction

    // Apply one accepted item to the shadow state and return the status it reports.
    function automatic result_t advance_fsm(input cmd_item_t it);
        result_t r;
        case (it.kind)
            OP_TICK: run_tick();
            OP_SETPOINT: begin
                steer_tgt  = pct_to_us(it.steer_pct, STEER_MIN_WIDTH, STEER_MAX_WIDTH);
                motor_tgt  = pct_to_us(it.motor_pct, MOTOR_MIN_WIDTH, MOTOR_MAX_WIDTH);
                steer_idle = '0;
                motor_idle = '0;
            end
            OP_REQUEST: begin
                if (it.req_code <= REQ_CODE_MAX)
                    req_latched = REQ_W'(it.req_code) + 1'b1;
            end
            default: begin
                if (it.vis_code != '0)
                    vis_err = 1'b1;
            end
        endcase
        r.from_tick   = (it.kind == OP_TICK);
        r.mode        = veh_mode;
        r.calib_stage = cal_stage;
        r.steer_width = steer_cmd;
        r.motor_width = motor_cmd;
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    // Mostly back to back, often a short pause, now and then a long one.
    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic signed [PCT_W-1:0] rand_pct();
        if ($urandom_range(0, 9) == 0)
            return PCT_W'($urandom);
        return PCT_W'(int'($urandom_range(0, 24000)) - 12000);
    endfunction

    function automatic logic [CODE_W-1:0] rand_vision();
        if ($urandom_range(0, 2) == 0)
            return '0;
        return CODE_W'($urandom_range(1, 255));
    endfunction

    task automatic push_item(input logic [OP_W-1:0] kind, input logic signed [PCT_W-1:0] sp,
                             input logic signed [PCT_W-1:0] mp,
                             input logic [CODE_W-1:0] rc, input logic [CODE_W-1:0] vc);
        cmd_item_t it;
        it.kind      = kind;
        it.steer_pct = sp;
        it.motor_pct = mp;
        it.req_code  = rc;
        it.vis_code  = vc;
        pending_cmds.push_back(it);
        queued++;
    endtask

    task automatic add_tick();
        push_item(OP_TICK, PCT_W'($urandom), PCT_W'($urandom), CODE_W'($urandom),
                  CODE_W'($urandom));
    endtask

    task automatic add_setpoint(input logic signed [PCT_W-1:0] sp,
                                input logic signed [PCT_W-1:0] mp);
        push_item(OP_SETPOINT, sp, mp, CODE_W'($urandom), CODE_W'($urandom));
    endtask

    task automatic add_request(input logic [CODE_W-1:0] rc);
        push_item(OP_REQUEST, PCT_W'($urandom), PCT_W'($urandom), rc, CODE_W'($urandom));
    endtask

    task automatic add_vision(input logic [CODE_W-1:0] vc);
        push_item(OP_VISION, PCT_W'($urandom), PCT_W'($urandom), CODE_W'($urandom), vc);
    endtask

    task automatic add_noise();
        push_item(OP_W'($urandom), PCT_W'($urandom), PCT_W'($urandom), CODE_W'($urandom),
                  CODE_W'($urandom));
    endtask

    // Prepare, perform, then run ticks; a full run lasts through all stages,
    // a short one is often cut off by a disable request.
    task automatic add_calibration(input bit full);
        int n;
        int r;
        int ticks;
        add_request(CODE_PREPARE);
        add_tick();
        add_request(CODE_PERFORM);
        add_tick();
        ticks = 0;
        n = full ? 200 + $urandom_range(0, 10) : $urandom_range(3, 30);
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 85) begin
                add_tick();
                ticks++;
            end else if (r < 93) begin
                add_setpoint(rand_pct(), rand_pct());
            end else if (r < 97) begin
                add_vision(rand_vision());
            end else begin
                add_request(CODE_W'($urandom_range(1, 255)));
            end
        end
        // A full run gets enough ticks to finish and drop back to disabled.
        if (full) begin
            while (ticks < FULL_CAL_TICKS) begin
                add_tick();
                ticks++;
            end
        end
        if (!full && $urandom_range(0, 1) == 1) begin
            add_request(CODE_DISABLE);
            add_tick();
        end
    endtask

    // Random traffic for one configuration: mostly enable sessions with
    // random content, some calibrations, some plain noise.
    task automatic run_phase(input int budget, input bit long_calib);
        int first;
        int r;
        int n;
        first = queued;
        if (long_calib)
            add_calibration(1'b1);
        while (queued - first < budget) begin
            no_idle = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 55) begin
                if ($urandom_range(0, 1) == 1)
                    add_setpoint(rand_pct(), rand_pct());
                add_request(CODE_ENABLE);
                repeat ($urandom_range(2, 8))
                    add_tick();
                n = $urandom_range(10, 40);
                repeat (n) begin
                    r = $urandom_range(0, 99);
                    if (r < 50)
                        add_tick();
                    else if (r < 75)
                        add_setpoint(rand_pct(), rand_pct());
                    else if (r < 85)
                        add_vision(rand_vision());
                    else if (r < 95)
                        add_request(CODE_W'($urandom_range(0, 12) == 0 ? 0 :
                                             $urandom_range(1, 255)));
                    else
                        add_noise();
                end
                if ($urandom_range(0, 1) == 1) begin
                    add_request(CODE_DISABLE);
                    add_tick();
                end
            end else if (r < 70) begin
                add_calibration(1'b0);
            end else begin
                repeat ($urandom_range(5, 15))
                    add_noise();
            end
        end
    endtask

    // Wait until every item is out and every status is back, then let the
    // pipeline settle.
    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_tvalid || expected_status.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge aclk);
        while (!cfg_ready);
        apply_reg(idx, val);
    endtask

    task automatic write_config(input cfg_t c);
        write_reg(CFG_STEER_NEUTRAL, CFG_DATA_W'(c.steer_neutral_width));
        write_reg(CFG_MOTOR_NEUTRAL, CFG_DATA_W'(c.motor_neutral_width));
        write_reg(CFG_STEER_STEP, CFG_DATA_W'(c.steer_slew_step));
        write_reg(CFG_MOTOR_STEP, CFG_DATA_W'(c.motor_slew_step));
        write_reg(CFG_NEED_NEUTRAL, CFG_DATA_W'(c.need_neutral_to_enable));
        write_reg(CFG_TIMEOUT_DIS, CFG_DATA_W'(c.timeout_may_disable));
        write_reg(CFG_VISION_DIS, CFG_DATA_W'(c.vision_may_disable));
        write_reg(CFG_TIMEOUT_TICKS, c.timeout_ticks);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Item driver: presents the next pending item once the current one is taken.
    always @(negedge aclk) begin : drive_items
        cmd_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                nxt = pending_cmds.pop_front();
                s_tdata  <= {nxt.vis_code, nxt.req_code, nxt.motor_pct, nxt.steer_pct};
                s_tuser  <= nxt.kind;
                s_tvalid <= 1'b1;
                send_gap = no_idle ? 0 : next_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Status sink with random back pressure.
    always @(negedge aclk) begin : drive_ready
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (sink_hold > 0) begin
            sink_hold--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            sink_hold = no_idle ? 0 : next_gap();
        end
    end

    // Monitor: check each status transfer, predict each item transfer, and
    // watch for a stuck handshake on any channel.
    always @(posedge aclk) begin : watch_ports
        cmd_item_t got;
        result_t   want;
        bit        moved;
        in_taken = 1'b0;
        moved    = 1'b0;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                moved = 1'b1;
                if (expected_status.size() == 0) begin
                    $error("status transfer with nothing expected: tuser %0d tdata %h",
                           m_tuser, m_tdata);
                    errors++;
                end else begin
                    want = expected_status.pop_front();
                    check_field("from_tick", want.from_tick, m_tuser[0]);
                    check_field("mode", want.mode, m_tdata[2:0]);
                    check_field("calib_stage", want.calib_stage, m_tdata[4:3]);
                    check_field("steer_width", want.steer_width, m_tdata[16:5]);
                    check_field("motor_width", want.motor_width, m_tdata[28:17]);
                end
            end
            if (s_tvalid && s_tready) begin
                moved         = 1'b1;
                in_taken      = 1'b1;
                got.kind      = s_tuser;
                got.steer_pct = s_tdata[15:0];
                got.motor_pct = s_tdata[31:16];
                got.req_code  = s_tdata[39:32];
                got.vis_code  = s_tdata[47:40];
                expected_status.push_back(advance_fsm(got));
            end
            if (cfg_valid && cfg_ready)
                moved = 1'b1;
            if (moved)
                idle_run = 0;
            else
                idle_run++;
            if (idle_run >= STALL_LIMIT) begin
                $display("esc_steering_safety_fsm: mismatch");
                $finish;
            end
        end
    end

    initial begin : stimulus
        cfg_t plan [5];
        shadow_reset();

        plan[0] = '{steer_neutral_width: 12'd1500, motor_neutral_width: 12'd1500,
                    steer_slew_step: 12'd10, motor_slew_step: 12'd10,
                    need_neutral_to_enable: 1'b1, timeout_may_disable: 1'b1,
                    vision_may_disable: 1'b1, timeout_ticks: 16'd20};
        plan[1] = '{steer_neutral_width: 12'd0, motor_neutral_width: 12'd4095,
                    steer_slew_step: 12'd4095, motor_slew_step: 12'd4095,
                    need_neutral_to_enable: 1'b0, timeout_may_disable: 1'b0,
                    vision_may_disable: 1'b0, timeout_ticks: 16'hFFFF};
        plan[2] = '{steer_neutral_width: 12'd4095, motor_neutral_width: 12'd0,
                    steer_slew_step: 12'd0, motor_slew_step: 12'd0,
                    need_neutral_to_enable: 1'b1, timeout_may_disable: 1'b1,
                    vision_may_disable: 1'b1, timeout_ticks: 16'd0};
        plan[3] = '{steer_neutral_width: PW_W'($urandom_range(900, 2100)),
                    motor_neutral_width: PW_W'($urandom_range(900, 2100)),
                    steer_slew_step: PW_W'($urandom_range(1, 200)),
                    motor_slew_step: PW_W'($urandom_range(1, 200)),
                    need_neutral_to_enable: 1'($urandom), timeout_may_disable: 1'($urandom),
                    vision_may_disable: 1'($urandom),
                    timeout_ticks: CNT_W'($urandom_range(0, 60))};
        plan[4] = '{steer_neutral_width: 12'd1400, motor_neutral_width: 12'd1600,
                    steer_slew_step: 12'd50, motor_slew_step: 12'd50,
                    need_neutral_to_enable: 1'b1, timeout_may_disable: 1'b1,
                    vision_may_disable: 1'b1, timeout_ticks: 16'd5};

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part under reset settings: percent extremes and clamping,
        // ignored request codes, zero and nonzero vision codes, enabling, a
        // vision trip, a calibration aborted by disable with the stage kept,
        // and a disable out of pre-calibrate.
        add_tick();
        add_setpoint(16'sh7FFF, 16'sh8000);
        add_setpoint(-16'sd10001, 16'sd10001);
        add_setpoint(16'sd10000, -16'sd10000);
        add_request(8'hFF);
        add_request(8'd4);
        add_vision(8'h00);
        add_vision(8'hFF);
        add_tick();
        add_request(CODE_ENABLE);
        add_tick();
        add_tick();
        add_setpoint(16'sh7FFF, 16'sh7FFF);
        add_tick();
        add_tick();
        add_vision(8'd1);
        add_tick();
        add_request(CODE_PREPARE);
        add_tick();
        add_request(CODE_PERFORM);
        add_tick();
        add_tick();
        add_request(CODE_DISABLE);
        add_tick();
        add_request(CODE_PREPARE);
        add_tick();
        add_request(CODE_DISABLE);
        add_tick();
        wait_drained();

        for (int i = 0; i < 5; i++) begin
            write_config(plan[i]);
            run_phase(180, i == 0 || i == 4);
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        if (errors == 0)
            $display("esc_steering_safety_fsm: match");
        else
            $display("esc_steering_safety_fsm: mismatch");
        $finish;
    end

endmodule
